>>> design/ooi_pkg.sv
// ----------------------------------------------------------------------------
// Odometry integrator package
// Shared types, codes and constants of the omnidirectional odometry filter
// and dead-reckoning integrator.
// ----------------------------------------------------------------------------
package ooi_pkg;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
        logic [15:0]        step_time;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic [31:0]        new_heading;
    } ooi_in_t;

    typedef struct packed {
        logic signed [15:0] filt_vx;
        logic signed [15:0] filt_vy;
        logic signed [15:0] rate_out;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading;
        logic [31:0]        var_x;
        logic [31:0]        var_y;
    } ooi_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_HORNER,
        ST_POST,
        ST_OUT
    } ooi_state_t;

    localparam logic [2:0] CFG_ALPHA_X    = 3'd0;
    localparam logic [2:0] CFG_ALPHA_Y    = 3'd1;
    localparam logic [2:0] CFG_COV_GAIN_X = 3'd2;
    localparam logic [2:0] CFG_COV_GAIN_Y = 3'd3;
    localparam logic [2:0] CFG_COV_LIMIT  = 3'd4;

    localparam logic       CMD_SAMPLE   = 1'b0;
    localparam logic       CMD_SET_POSE = 1'b1;

    localparam logic [16:0] ALPHA_ONE   = 17'd65536;
    localparam logic [31:0] VAR_FLOOR   = 32'd43;
    localparam logic [31:0] RAD_K       = 32'd1367130551;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam int          RECIP_SHIFT = 33;

    // Horner divisors: sine terms first, then cosine terms.
    function automatic logic [6:0] horner_div(input logic [3:0] idx);
        logic [6:0] d;
        unique case (idx)
            4'd0:    d = 7'd72;
            4'd1:    d = 7'd42;
            4'd2:    d = 7'd20;
            4'd3:    d = 7'd6;
            4'd4:    d = 7'd90;
            4'd5:    d = 7'd56;
            4'd6:    d = 7'd30;
            4'd7:    d = 7'd12;
            default: d = 7'd2;
        endcase
        return d;
    endfunction

    // Reciprocal floor(2^33 / d) for the divisor of the same index.
    function automatic logic [32:0] horner_recip(input logic [3:0] idx);
        logic [32:0] m;
        unique case (idx)
            4'd0:    m = 33'((64'd1 << RECIP_SHIFT) / 64'd72);
            4'd1:    m = 33'((64'd1 << RECIP_SHIFT) / 64'd42);
            4'd2:    m = 33'((64'd1 << RECIP_SHIFT) / 64'd20);
            4'd3:    m = 33'((64'd1 << RECIP_SHIFT) / 64'd6);
            4'd4:    m = 33'((64'd1 << RECIP_SHIFT) / 64'd90);
            4'd5:    m = 33'((64'd1 << RECIP_SHIFT) / 64'd56);
            4'd6:    m = 33'((64'd1 << RECIP_SHIFT) / 64'd30);
            4'd7:    m = 33'((64'd1 << RECIP_SHIFT) / 64'd12);
            default: m = 33'((64'd1 << RECIP_SHIFT) / 64'd2);
        endcase
        return m;
    endfunction

endpackage

>>> design/omni_odometry_filter_integrator.sv
// ----------------------------------------------------------------------------
// Omnidirectional odometry filter and integrator
// Filters body velocities, grows clamped variances and dead-reckons the pose
// with one shared multiplier under a step sequencer; a set-pose request loads the pose.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on sample/sample_valid and is taken when sample_stall is
// low. An odometry sample is worked through in steps on a single 34 x 34
// bit signed multiplier: filters, variances, heading, a polynomial sine and
// cosine (nine Horner steps, divisions done by reciprocal multiplication)
// and the rotation of the displacement. A set-pose request loads the pose
// without the multiplier. The result then appears on pose/pose_valid,
// holding the state after the update, and stays there while pose_stall is
// high. sample_stall is high from acceptance until the result has been
// taken, so one request is in flight at a time and the block takes no new
// sample before it is through with the last one.
// Reset clears the filter state, the pose and the variances and loads the
// default coefficients. Configuration writes via cfg_we, cfg_index and
// cfg_data are expected only while the block is idle.
// ----------------------------------------------------------------------------
module omni_odometry_filter_integrator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    output logic            sample_stall,
    input  ooi_pkg::ooi_in_t  sample,
    output logic            pose_valid,
    input  logic            pose_stall,
    output ooi_pkg::ooi_out_t pose,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import ooi_pkg::*;

    ooi_state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [3:0] hidx_reg, hidx_next;
    logic [1:0] hph_reg, hph_next;

    logic [16:0] alpha_x_reg, alpha_y_reg;
    logic [31:0] gain_x_reg, gain_y_reg, limit_reg;

    logic signed [15:0] vxf_reg, vxf_next, vyf_reg, vyf_next, rate_reg, rate_next;
    logic [31:0] varx_reg, varx_next, vary_reg, vary_next;
    logic signed [31:0] posx_reg, posx_next, posy_reg, posy_next;
    logic [31:0] head_reg, head_next;

    ooi_in_t item_reg, item_next;
    logic signed [67:0] prod_reg, acc_reg, acc_next;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic [1:0]  quad_reg, quad_next;
    logic        swap_reg, swap_next;
    logic [29:0] t_reg, t_next, x_reg, x_next, x2_reg, x2_next, dv_reg, dv_next;
    logic [30:0] pv_reg, pv_next, sinp_reg, sinp_next;
    logic signed [31:0] dx_reg, dx_next, dy_reg, dy_next, s_reg, s_next, c_reg, c_next;

    logic [16:0] aa_x, aa_y, mag_x, mag_y;
    logic signed [67:0] ema_sum, hsum_full, hsum_half, rot_sum;
    logic [45:0] gsum_x, gsum_y;
    logic [31:0] full_ang, half_ang, mid_ang;
    logic [29:0] qe, q_fix;
    logic [36:0] qd;
    logic [30:0] rem;
    logic [6:0]  dsel;
    logic [30:0] s0, c0, sr, cr;
    logic signed [25:0] delta;

    assign aa_x  = (alpha_x_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_x_reg;
    assign aa_y  = (alpha_y_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_y_reg;
    assign mag_x = item_reg.vel_x[15] ? (17'd0 - {item_reg.vel_x[15], item_reg.vel_x})
                                      : {1'b0, item_reg.vel_x};
    assign mag_y = item_reg.vel_y[15] ? (17'd0 - {item_reg.vel_y[15], item_reg.vel_y})
                                      : {1'b0, item_reg.vel_y};

    assign mul_p = mul_a * mul_b;

    assign ema_sum   = acc_reg + prod_reg + 68'sd32768;
    assign gsum_x    = {1'b0, prod_reg[48:4]} + {14'd0, varx_reg};
    assign gsum_y    = {1'b0, prod_reg[48:4]} + {14'd0, vary_reg};
    assign hsum_full = prod_reg + (68'sd1 <<< 29);
    assign hsum_half = prod_reg + (68'sd1 <<< 30);
    assign full_ang  = hsum_full[61:30];
    assign half_ang  = hsum_half[62:31];
    assign mid_ang   = head_reg + half_ang;

    // Reciprocal quotient may fall short by one; a single correction fixes it.
    assign dsel  = horner_div(hidx_reg);
    assign qe    = prod_reg[RECIP_SHIFT+29:RECIP_SHIFT];
    assign qd    = qe * dsel;
    assign rem   = {1'b0, dv_reg} - qd[30:0];
    assign q_fix = (rem >= {24'd0, dsel}) ? (qe + 30'd1) : qe;

    assign s0 = prod_reg[60:30];
    assign c0 = pv_reg;
    assign sr = swap_reg ? c0 : s0;
    assign cr = swap_reg ? s0 : c0;

    function automatic logic [31:0] clamp_var(input logic [45:0] v, input logic [31:0] lim);
        logic [45:0] f;
        f = (v < {14'd0, VAR_FLOOR}) ? {14'd0, VAR_FLOOR} : v;
        if (f > {14'd0, lim})
            f = {14'd0, lim};
        return f[31:0];
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                   input logic signed [25:0] d);
        logic signed [33:0] s;
        s = {{2{p[31]}}, p} + {{8{d[25]}}, d};
        if (s > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (s < -34'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        hidx_next  = hidx_reg;
        hph_next   = hph_reg;
        vxf_next   = vxf_reg;
        vyf_next   = vyf_reg;
        rate_next  = rate_reg;
        varx_next  = varx_reg;
        vary_next  = vary_reg;
        posx_next  = posx_reg;
        posy_next  = posy_reg;
        head_next  = head_reg;
        item_next  = item_reg;
        acc_next   = acc_reg;
        quad_next  = quad_reg;
        swap_next  = swap_reg;
        t_next     = t_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        dv_next    = dv_reg;
        pv_next    = pv_reg;
        sinp_next  = sinp_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        s_next     = s_reg;
        c_next     = c_reg;
        mul_a      = '0;
        mul_b      = '0;
        rot_sum    = '0;
        delta      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    item_next = sample;
                    if (sample.cmd == CMD_SET_POSE)
                    begin
                        posx_next  = sample.new_x;
                        posy_next  = sample.new_y;
                        head_next  = sample.new_heading;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        step_next  = 4'd0;
                        state_next = ST_PRE;
                    end
                end
            end
            ST_PRE:
            begin
                step_next = step_reg + 4'd1;
                unique case (step_reg)
                    4'd0:
                    begin
                        mul_a = {17'd0, aa_x};
                        mul_b = {{18{item_reg.vel_x[15]}}, item_reg.vel_x};
                    end
                    4'd1:
                    begin
                        acc_next = prod_reg;
                        mul_a    = {17'd0, ALPHA_ONE - aa_x};
                        mul_b    = {{18{vxf_reg[15]}}, vxf_reg};
                    end
                    4'd2:
                    begin
                        vxf_next = ema_sum[31:16];
                        mul_a    = {17'd0, aa_y};
                        mul_b    = {{18{item_reg.vel_y[15]}}, item_reg.vel_y};
                    end
                    4'd3:
                    begin
                        acc_next = prod_reg;
                        mul_a    = {17'd0, ALPHA_ONE - aa_y};
                        mul_b    = {{18{vyf_reg[15]}}, vyf_reg};
                    end
                    4'd4:
                    begin
                        vyf_next = ema_sum[31:16];
                        mul_a    = {2'd0, gain_x_reg};
                        mul_b    = {17'd0, mag_x};
                    end
                    4'd5:
                    begin
                        varx_next = clamp_var(gsum_x, limit_reg);
                        mul_a     = {2'd0, gain_y_reg};
                        mul_b     = {17'd0, mag_y};
                    end
                    4'd6:
                    begin
                        vary_next = clamp_var(gsum_y, limit_reg);
                        rate_next = item_reg.yaw_rate;
                        mul_a     = {{18{item_reg.yaw_rate[15]}}, item_reg.yaw_rate};
                        mul_b     = {18'd0, item_reg.step_time};
                    end
                    4'd7:
                    begin
                        mul_a = {{2{prod_reg[31]}}, prod_reg[31:0]};
                        mul_b = {2'd0, RAD_K};
                    end
                    4'd8:
                    begin
                        head_next = head_reg + full_ang;
                        quad_next = mid_ang[31:30];
                        if (mid_ang[29:0] <= 30'h20000000)
                        begin
                            swap_next = 1'b0;
                            t_next    = mid_ang[29:0];
                        end
                        else
                        begin
                            swap_next = 1'b1;
                            t_next    = 30'h3FFFFFFF - mid_ang[29:0] + 30'd1;
                        end
                        mul_a = {{18{vxf_reg[15]}}, vxf_reg};
                        mul_b = {18'd0, item_reg.step_time};
                    end
                    4'd9:
                    begin
                        dx_next = prod_reg[31:0];
                        mul_a   = {{18{vyf_reg[15]}}, vyf_reg};
                        mul_b   = {18'd0, item_reg.step_time};
                    end
                    4'd10:
                    begin
                        dy_next = prod_reg[31:0];
                        mul_a   = {4'd0, t_reg};
                        mul_b   = {2'd0, PI_Q30};
                    end
                    4'd11:
                    begin
                        rot_sum = prod_reg + (68'sd1 <<< 30);
                        x_next  = rot_sum[60:31];
                    end
                    4'd12:
                    begin
                        mul_a = {4'd0, x_reg};
                        mul_b = {4'd0, x_reg};
                    end
                    default:
                    begin
                        x2_next    = prod_reg[59:30];
                        dv_next    = prod_reg[59:30];
                        hidx_next  = 4'd0;
                        hph_next   = 2'd2;
                        state_next = ST_HORNER;
                    end
                endcase
            end
            ST_HORNER:
            begin
                hph_next = hph_reg + 2'd1;
                unique case (hph_reg)
                    2'd0:
                    begin
                        mul_a = {4'd0, x2_reg};
                        mul_b = {3'd0, pv_reg};
                    end
                    2'd1:
                    begin
                        dv_next = prod_reg[59:30];
                    end
                    2'd2:
                    begin
                        mul_a = {4'd0, dv_reg};
                        mul_b = {1'b0, horner_recip(hidx_reg)};
                    end
                    default:
                    begin
                        pv_next = ONE_Q30 - {1'b0, q_fix};
                        if (hidx_reg == 4'd3)
                        begin
                            sinp_next = ONE_Q30 - {1'b0, q_fix};
                            dv_next   = x2_reg;
                            hidx_next = 4'd4;
                            hph_next  = 2'd2;
                        end
                        else if (hidx_reg == 4'd8)
                        begin
                            step_next  = 4'd0;
                            state_next = ST_POST;
                        end
                        else
                        begin
                            hidx_next = hidx_reg + 4'd1;
                        end
                    end
                endcase
            end
            ST_POST:
            begin
                step_next = step_reg + 4'd1;
                unique case (step_reg)
                    4'd0:
                    begin
                        mul_a = {4'd0, x_reg};
                        mul_b = {3'd0, sinp_reg};
                    end
                    4'd1:
                    begin
                        unique case (quad_reg)
                            2'd0:
                            begin
                                s_next = {1'b0, sr};
                                c_next = {1'b0, cr};
                            end
                            2'd1:
                            begin
                                s_next = {1'b0, cr};
                                c_next = -$signed({1'b0, sr});
                            end
                            2'd2:
                            begin
                                s_next = -$signed({1'b0, sr});
                                c_next = -$signed({1'b0, cr});
                            end
                            default:
                            begin
                                s_next = -$signed({1'b0, cr});
                                c_next = {1'b0, sr};
                            end
                        endcase
                    end
                    4'd2:
                    begin
                        mul_a = {{2{c_reg[31]}}, c_reg};
                        mul_b = {{2{dx_reg[31]}}, dx_reg};
                    end
                    4'd3:
                    begin
                        acc_next = prod_reg;
                        mul_a    = {{2{s_reg[31]}}, s_reg};
                        mul_b    = {{2{dy_reg[31]}}, dy_reg};
                    end
                    4'd4:
                    begin
                        rot_sum   = acc_reg - prod_reg + (68'sd1 <<< 41);
                        delta     = rot_sum[67:42];
                        posx_next = sat_add(posx_reg, delta);
                        mul_a     = {{2{s_reg[31]}}, s_reg};
                        mul_b     = {{2{dx_reg[31]}}, dx_reg};
                    end
                    4'd5:
                    begin
                        acc_next = prod_reg;
                        mul_a    = {{2{c_reg[31]}}, c_reg};
                        mul_b    = {{2{dy_reg[31]}}, dy_reg};
                    end
                    default:
                    begin
                        rot_sum    = acc_reg + prod_reg + (68'sd1 <<< 41);
                        delta      = rot_sum[67:42];
                        posy_next  = sat_add(posy_reg, delta);
                        state_next = ST_OUT;
                    end
                endcase
            end
            default:
            begin
                if (!pose_stall)
                    state_next = ST_IDLE;
            end
        endcase
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign pose_valid   = (state_reg == ST_OUT);

    always_comb
    begin
        pose.filt_vx  = vxf_reg;
        pose.filt_vy  = vyf_reg;
        pose.rate_out = rate_reg;
        pose.pos_x    = posx_reg;
        pose.pos_y    = posy_reg;
        pose.heading  = head_reg;
        pose.var_x    = varx_reg;
        pose.var_y    = vary_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            hidx_reg    <= '0;
            hph_reg     <= '0;
            alpha_x_reg <= 17'd32768;
            alpha_y_reg <= 17'd32768;
            gain_x_reg  <= '0;
            gain_y_reg  <= '0;
            limit_reg   <= 32'd429496730;
            vxf_reg     <= '0;
            vyf_reg     <= '0;
            rate_reg    <= '0;
            varx_reg    <= '0;
            vary_reg    <= '0;
            posx_reg    <= '0;
            posy_reg    <= '0;
            head_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            hidx_reg  <= hidx_next;
            hph_reg   <= hph_next;
            vxf_reg   <= vxf_next;
            vyf_reg   <= vyf_next;
            rate_reg  <= rate_next;
            varx_reg  <= varx_next;
            vary_reg  <= vary_next;
            posx_reg  <= posx_next;
            posy_reg  <= posy_next;
            head_reg  <= head_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ALPHA_X:    alpha_x_reg <= cfg_data[16:0];
                    CFG_ALPHA_Y:    alpha_y_reg <= cfg_data[16:0];
                    CFG_COV_GAIN_X: gain_x_reg  <= cfg_data;
                    CFG_COV_GAIN_Y: gain_y_reg  <= cfg_data;
                    CFG_COV_LIMIT:  limit_reg   <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        item_reg <= item_next;
        acc_reg  <= acc_next;
        quad_reg <= quad_next;
        swap_reg <= swap_next;
        t_reg    <= t_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        dv_reg   <= dv_next;
        pv_reg   <= pv_next;
        sinp_reg <= sinp_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        s_reg    <= s_next;
        c_reg    <= c_next;
    end

endmodule
